[design/srpf_pkg.sv]
package srpf_pkg;

    // Default sizing of the range store
    localparam int COUNTERS_DEF = 11;
    localparam int SLOTS_DEF    = 8;

    // Field widths fixed by the interface
    localparam int MASK_W  = 11;
    localparam int CIDX_W  = 4;
    localparam int SLOT_W  = 3;
    localparam int VAL_W   = 32;
    localparam int MATCH_W = 4;

    // Highest counter index that the enable mask can cover
    localparam logic [CIDX_W-1:0] LAST_MASKED_COUNTER = 4'd10;

    // Reported when no slot matches
    localparam logic signed [MATCH_W-1:0] MATCH_NONE = -4'sd1;

    // Request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Entry kinds
    typedef enum logic [1:0] {
        KIND_BOUNDED   = 2'd0,
        KIND_LOWER     = 2'd1,
        KIND_UPPER     = 2'd2,
        KIND_UNBOUNDED = 2'd3
    } t_kind;

    // One stored range entry (valid bit held apart in flip-flops)
    typedef struct packed {
        t_kind              kind;
        logic [VAL_W-1:0]   from_val;
        logic [VAL_W-1:0]   to_val;
        logic [VAL_W-1:0]   stride;
    } t_entry;

endpackage

[design/strided_range_page_filter.sv]
// Strided range page filter.
// Requests enter on the command channel: a request is taken at a rising edge with
// start high and busy low. A write request (op = write) loads one range entry of one
// counter's list; a query request tests one counter value against that counter's list.
// Every request gives exactly one result on o_match_slot / o_page_done /
// o_page_selected, shown for one cycle with o_strobe. The receiver cannot stall, so a
// result is never held back; the next request may be taken while the strobe is high.
// The enable mask is written on its own valid/ready channel, which is always ready.
// A write gives its result in the cycle after it is taken. A query on a disabled counter
// goes straight to its result. An enabled query walks the slots in order up to the first
// matching slot: it skips invalid slots, settles a valid slot by the equality, bound or
// zero-stride test where it can, and else runs the divisibility test. A query that
// matches no slot walks every slot and then ends the list. The divisibility test is a
// bit-serial restoring remainder, one dividend bit a cycle, and is the longest step;
// queries are handled one at a time.
// Reset: every entry is marked invalid at once (valid bits in flip-flops), the enable
// mask clears and the running page flag is set. Entry payload is undefined until
// written.
module strided_range_page_filter #(
    parameter int COUNTERS = srpf_pkg::COUNTERS_DEF,
    parameter int SLOTS    = srpf_pkg::SLOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_op,
    input  logic [srpf_pkg::CIDX_W-1:0]           i_counter_index,
    input  logic [srpf_pkg::SLOT_W-1:0]           i_slot,
    input  logic [1:0]                            i_entry_kind,
    input  logic                                  i_entry_valid,
    input  logic signed [srpf_pkg::VAL_W-1:0]     i_bound_from,
    input  logic signed [srpf_pkg::VAL_W-1:0]     i_bound_to,
    input  logic signed [srpf_pkg::VAL_W-1:0]     i_stride,
    input  logic signed [srpf_pkg::VAL_W-1:0]     i_counter_value,
    input  logic                                  i_last_counter,
    // result
    output logic                                  o_strobe,
    output logic signed [srpf_pkg::MATCH_W-1:0]   o_match_slot,
    output logic                                  o_page_done,
    output logic                                  o_page_selected,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [srpf_pkg::MASK_W-1:0]           i_cfg_data
);

    localparam int DEPTH = COUNTERS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int JW    = $clog2(SLOTS + 1);
    localparam int VW    = srpf_pkg::VAL_W;
    localparam int CW    = $clog2(VW);
    localparam logic [AW-1:0] SLOTS_A  = AW'(SLOTS);
    localparam logic [JW-1:0] SLOTS_J  = JW'(SLOTS);
    localparam logic [CW-1:0] LAST_BIT = CW'(VW - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TEST,
        S_PREP,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                      r_state;
    logic [srpf_pkg::MASK_W-1:0] r_mask;
    logic                        r_valid [DEPTH];
    logic                        r_page_sel;
    logic                        r_strobe;
    logic signed [srpf_pkg::MATCH_W-1:0] r_match_slot;
    logic                        r_page_done;
    logic                        r_page_selected;

    // held query
    logic [AW-1:0]               r_base;
    logic [VW-1:0]               r_value;
    logic                        r_last;
    logic                        r_en;
    logic                        r_hit;
    logic [JW-1:0]               r_j;

    // slot test and remainder datapath
    srpf_pkg::t_entry            r_rd;
    srpf_pkg::t_entry            mem [DEPTH];
    logic [VW:0]                 r_diff;
    logic [VW-1:0]               r_dvd;
    logic [VW-1:0]               r_dvs;
    logic [VW-1:0]               r_rem;
    logic [CW-1:0]               r_cnt;

    logic                        accept;
    logic                        in_range_ci;
    logic                        in_range_wr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               in_base;
    logic [srpf_pkg::MASK_W-1:0] mask_shift;
    logic                        q_enabled;
    logic [AW-1:0]               scan_addr;
    logic                        scan_end;
    logic                        slot_live;
    srpf_pkg::t_entry            wr_data;

    logic signed [VW-1:0]        t_v;
    logic signed [VW-1:0]        t_f;
    logic signed [VW-1:0]        t_t;
    logic signed [VW-1:0]        t_s;
    logic [VW-1:0]               t_ref;
    logic                        t_eq;
    logic                        t_cond;
    logic [VW:0]                 n_diff;

    logic [VW:0]                 n_rem_sh;
    logic [VW:0]                 n_rem_sub;
    logic [VW-1:0]               n_rem;
    logic                        flag_after;

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign o_cfg_ready     = 1'b1;
    assign o_strobe        = r_strobe;
    assign o_match_slot    = r_match_slot;
    assign o_page_done     = r_page_done;
    assign o_page_selected = r_page_selected;

    // Request decode at accept
    assign in_range_ci = (32'(i_counter_index) < COUNTERS);
    assign in_range_wr = in_range_ci && (32'(i_slot) < SLOTS);
    assign in_base     = AW'(i_counter_index) * SLOTS_A;
    assign wr_addr     = in_base + AW'(i_slot);
    assign wr_en       = accept && (i_op == srpf_pkg::OP_WRITE) && in_range_wr;
    assign mask_shift  = r_mask >> i_counter_index;
    assign q_enabled   = in_range_ci && (i_counter_index <= srpf_pkg::LAST_MASKED_COUNTER)
                         && mask_shift[0];

    assign wr_data.kind     = srpf_pkg::t_kind'(i_entry_kind);
    assign wr_data.from_val = i_bound_from;
    assign wr_data.to_val   = i_bound_to;
    assign wr_data.stride   = i_stride;

    // Slot walk
    assign scan_end  = (r_j == SLOTS_J);
    assign scan_addr = r_base + AW'(r_j[SW-1:0]);
    assign slot_live = (r_state == S_SCAN) && !scan_end && r_valid[scan_addr];

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (slot_live) begin
            r_rd <= mem[scan_addr];
        end
    end

    // Equality early-out, step-signed bound test and difference for one entry
    always_comb begin
        t_v    = $signed(r_value);
        t_f    = $signed(r_rd.from_val);
        t_t    = $signed(r_rd.to_val);
        t_s    = $signed(r_rd.stride);
        t_ref  = r_rd.from_val;
        t_eq   = 1'b0;
        t_cond = 1'b1;
        unique case (r_rd.kind)
            srpf_pkg::KIND_BOUNDED: begin
                t_eq   = (t_v == t_f);
                t_cond = t_s[VW-1] ? ((t_v <= t_f) && (t_v >= t_t))
                                   : ((t_v <= t_t) && (t_v >= t_f));
            end
            srpf_pkg::KIND_LOWER: begin
                t_eq   = (t_v == t_f);
                t_cond = t_s[VW-1] ? (t_v < t_f) : (t_v > t_f);
            end
            srpf_pkg::KIND_UPPER: begin
                t_ref  = r_rd.to_val;
                t_eq   = (t_v == t_t);
                t_cond = t_s[VW-1] ? (t_v > t_t) : (t_v < t_t);
            end
            srpf_pkg::KIND_UNBOUNDED: begin
                t_ref  = '0;
            end
        endcase
        n_diff = {r_value[VW-1], r_value} - {t_ref[VW-1], t_ref};
    end

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_rem_sh  = {r_rem, r_dvd[VW-1]};
        n_rem_sub = n_rem_sh - {1'b0, r_dvs};
        n_rem     = n_rem_sub[VW] ? n_rem_sh[VW-1:0] : n_rem_sub[VW-1:0];
    end

    // A miss on an enabled counter drops the page
    assign flag_after = r_page_sel && !(r_en && !r_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strobe   <= 1'b0;
            r_page_sel <= 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_base  <= in_base;
                        r_value <= i_counter_value;
                        r_last  <= i_last_counter;
                        r_j     <= '0;
                        r_hit   <= 1'b0;
                        if (i_op == srpf_pkg::OP_WRITE) begin
                            // Store the entry and answer at once
                            if (in_range_wr) begin
                                r_valid[wr_addr] <= i_entry_valid;
                            end
                            r_strobe        <= 1'b1;
                            r_match_slot    <= srpf_pkg::MATCH_NONE;
                            r_page_done     <= 1'b0;
                            r_page_selected <= 1'b0;
                        end else begin
                            r_en    <= q_enabled;
                            r_state <= q_enabled ? S_SCAN : S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    // Skip invalid slots; a valid one is read into r_rd
                    if (scan_end) begin
                        r_state <= S_FINISH;
                    end else if (slot_live) begin
                        r_state <= S_TEST;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_TEST: begin
                    r_diff <= n_diff;
                    if (t_eq) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (!t_cond || (r_rd.stride == '0)) begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Magnitudes of difference and step for the remainder loop
                    r_dvd   <= r_diff[VW] ? VW'(~r_diff + 1'b1) : r_diff[VW-1:0];
                    r_dvs   <= r_rd.stride[VW-1] ? (~r_rd.stride + 1'b1) : r_rd.stride;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[VW-2:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == LAST_BIT) begin
                        if (n_rem == '0) begin
                            r_hit   <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_j     <= r_j + JW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FINISH: begin
                    r_strobe     <= 1'b1;
                    r_match_slot <= r_hit ? $signed(srpf_pkg::MATCH_W'(r_j))
                                          : srpf_pkg::MATCH_NONE;
                    if (r_last) begin
                        // Report the page and re-arm the flag
                        r_page_done     <= 1'b1;
                        r_page_selected <= flag_after;
                        r_page_sel      <= 1'b1;
                    end else begin
                        r_page_done     <= 1'b0;
                        r_page_selected <= 1'b0;
                        r_page_sel      <= flag_after;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_sel_only_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_page_done |-> !o_page_selected)
        else $error("page_selected raised without page_done");

    a_no_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvs != '0)
        else $error("remainder loop entered with zero step");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_dvs)
        else $error("partial remainder not reduced");

    a_write_answers_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == srpf_pkg::OP_WRITE
        |=> o_strobe && o_match_slot == srpf_pkg::MATCH_NONE && !o_page_done)
        else $error("write request not answered in the next cycle");

    a_flag_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_page_done |-> r_page_sel)
        else $error("page flag not re-armed after page report");

endmodule

[tb/tb_strided_range_page_filter.sv]
module tb_strided_range_page_filter;

    localparam int N_COUNTERS    = srpf_pkg::COUNTERS_DEF;
    localparam int N_SLOTS       = srpf_pkg::SLOTS_DEF;
    localparam int N_ENTRIES     = N_COUNTERS * N_SLOTS;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int ITEMS_TARGET  = 1100;
    localparam int STREAM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 50;
    localparam int MAX_REPORTS   = 10;
    localparam logic signed [srpf_pkg::VAL_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [srpf_pkg::VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

    // One request as seen on the command channel
    typedef struct packed {
        logic                              op;
        logic [srpf_pkg::CIDX_W-1:0]       counter;
        logic [srpf_pkg::SLOT_W-1:0]       slot;
        srpf_pkg::t_kind                   kind;
        logic                              entry_valid;
        logic signed [srpf_pkg::VAL_W-1:0] from_val;
        logic signed [srpf_pkg::VAL_W-1:0] to_val;
        logic signed [srpf_pkg::VAL_W-1:0] stride;
        logic signed [srpf_pkg::VAL_W-1:0] value;
        logic                              last;
    } t_filter_request;

    // One result as it should appear under the strobe
    typedef struct packed {
        logic signed [srpf_pkg::MATCH_W-1:0] slot;
        logic                                done;
        logic                                selected;
    } t_filter_result;

    // DUT ports: every input starts at a known value
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic                                i_op = srpf_pkg::OP_WRITE;
    logic [srpf_pkg::CIDX_W-1:0]         i_counter_index = '0;
    logic [srpf_pkg::SLOT_W-1:0]         i_slot = '0;
    logic [1:0]                          i_entry_kind = srpf_pkg::KIND_BOUNDED;
    logic                                i_entry_valid = 1'b0;
    logic signed [srpf_pkg::VAL_W-1:0]   i_bound_from = '0;
    logic signed [srpf_pkg::VAL_W-1:0]   i_bound_to = '0;
    logic signed [srpf_pkg::VAL_W-1:0]   i_stride = '0;
    logic signed [srpf_pkg::VAL_W-1:0]   i_counter_value = '0;
    logic                                i_last_counter = 1'b0;
    logic                                o_strobe;
    logic signed [srpf_pkg::MATCH_W-1:0] o_match_slot;
    logic                                o_page_done;
    logic                                o_page_selected;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [srpf_pkg::MASK_W-1:0]         i_cfg_data = '0;

    // Shadow copy of the range store, the enable mask and the running page flag
    logic                              entry_live [N_ENTRIES];
    logic                              entry_seen [N_ENTRIES];
    srpf_pkg::t_kind                   entry_kind_m [N_ENTRIES];
    logic signed [srpf_pkg::VAL_W-1:0] entry_from_m [N_ENTRIES];
    logic signed [srpf_pkg::VAL_W-1:0] entry_to_m [N_ENTRIES];
    logic signed [srpf_pkg::VAL_W-1:0] entry_stride_m [N_ENTRIES];
    logic [srpf_pkg::MASK_W-1:0]       enable_mask_m = '0;
    logic                              page_still_ok = 1'b1;

    t_filter_result expected_results [$];

    int  requests_sent = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  writes_seen = 0;
    int  queries_seen = 0;
    int  slot_hits = 0;
    int  pages_closed = 0;
    int  pages_selected = 0;
    int  masks_applied = 0;
    bit  idle_enabled = 1'b1;

    strided_range_page_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_counter_index (i_counter_index),
        .i_slot          (i_slot),
        .i_entry_kind    (i_entry_kind),
        .i_entry_valid   (i_entry_valid),
        .i_bound_from    (i_bound_from),
        .i_bound_to      (i_bound_to),
        .i_stride        (i_stride),
        .i_counter_value (i_counter_value),
        .i_last_counter  (i_last_counter),
        .o_strobe        (o_strobe),
        .o_match_slot    (o_match_slot),
        .o_page_done     (o_page_done),
        .o_page_selected (o_page_selected),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divisibility on the widened difference; a zero stride never divides
    function automatic logic stride_divides(input longint diff,
                                            input logic signed [srpf_pkg::VAL_W-1:0] s);
        if (s == 0)
            return 1'b0;
        return (diff % longint'(s)) == 0;
    endfunction

    function automatic logic entry_hits(input srpf_pkg::t_kind k,
                                        input logic signed [srpf_pkg::VAL_W-1:0] f,
                                        input logic signed [srpf_pkg::VAL_W-1:0] t,
                                        input logic signed [srpf_pkg::VAL_W-1:0] s,
                                        input logic signed [srpf_pkg::VAL_W-1:0] v);
        logic in_range;
        case (k)
            srpf_pkg::KIND_BOUNDED: begin
                if (v == f)
                    return 1'b1;
                // negative stride walks downwards from the start value
                in_range = (s < 0) ? (v <= f && v >= t) : (v >= f && v <= t);
                return in_range && stride_divides(longint'(v) - longint'(f), s);
            end
            srpf_pkg::KIND_LOWER: begin
                if (v == f)
                    return 1'b1;
                in_range = (s < 0) ? (v < f) : (v > f);
                return in_range && stride_divides(longint'(v) - longint'(f), s);
            end
            srpf_pkg::KIND_UPPER: begin
                if (v == t)
                    return 1'b1;
                in_range = (s < 0) ? (v > t) : (v < t);
                return in_range && stride_divides(longint'(v) - longint'(t), s);
            end
            default: return stride_divides(longint'(v), s);
        endcase
    endfunction

    // Advance the shadow state by one accepted request and return its result
    function automatic t_filter_result predict_filter_result(input t_filter_request r);
        t_filter_result res;
        int             idx;
        logic           enabled;
        res.slot     = srpf_pkg::MATCH_NONE;
        res.done     = 1'b0;
        res.selected = 1'b0;
        if (r.op == srpf_pkg::OP_WRITE) begin
            writes_seen++;
            // out-of-range counters store nothing
            if (r.counter < N_COUNTERS && r.slot < N_SLOTS) begin
                idx = int'(r.counter) * N_SLOTS + int'(r.slot);
                entry_live[idx]     = r.entry_valid;
                entry_seen[idx]     = 1'b1;
                entry_kind_m[idx]   = r.kind;
                entry_from_m[idx]   = r.from_val;
                entry_to_m[idx]     = r.to_val;
                entry_stride_m[idx] = r.stride;
            end
        end else begin
            queries_seen++;
            enabled = r.counter < N_COUNTERS &&
                      r.counter <= srpf_pkg::LAST_MASKED_COUNTER &&
                      enable_mask_m[r.counter];
            if (enabled) begin
                // walk the list in slot order, stop on the first hit
                for (int j = 0; j < N_SLOTS; j++) begin
                    idx = int'(r.counter) * N_SLOTS + j;
                    if (res.slot == srpf_pkg::MATCH_NONE && entry_live[idx] &&
                        entry_hits(entry_kind_m[idx], entry_from_m[idx], entry_to_m[idx],
                                   entry_stride_m[idx], r.value))
                        res.slot = srpf_pkg::MATCH_W'(j);
                end
                if (res.slot == srpf_pkg::MATCH_NONE)
                    page_still_ok = 1'b0;
                else
                    slot_hits++;
            end
            // the page closes whether or not the counter was enabled
            if (r.last) begin
                res.done      = 1'b1;
                res.selected  = page_still_ok;
                page_still_ok = 1'b1;
                pages_closed++;
                if (res.selected)
                    pages_selected++;
            end
        end
        return res;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endfunction

    // Check each strobed result, then capture the request taken at this edge.
    // Results are compared first: a result can never belong to a request
    // accepted at the same edge.
    always @(posedge i_clk) begin
        t_filter_result  want;
        t_filter_request req;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (o_strobe !== 1'b1 || expected_results.size() == 0) begin
                    note_mismatch($sformatf("result with no request pending: strobe %b slot %0d",
                                            o_strobe, o_match_slot));
                end else begin
                    want = expected_results.pop_front();
                    if (o_match_slot !== want.slot || o_page_done !== want.done ||
                        o_page_selected !== want.selected)
                        note_mismatch($sformatf(
                            "expected slot %0d done %b selected %b, got slot %0d done %b selected %b",
                            want.slot, want.done, want.selected,
                            o_match_slot, o_page_done, o_page_selected));
                end
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1)
                enable_mask_m = i_cfg_data;
            if (start && busy === 1'b0) begin
                req.op          = i_op;
                req.counter     = i_counter_index;
                req.slot        = i_slot;
                req.kind        = srpf_pkg::t_kind'(i_entry_kind);
                req.entry_valid = i_entry_valid;
                req.from_val    = i_bound_from;
                req.to_val      = i_bound_to;
                req.stride      = i_stride;
                req.value       = i_counter_value;
                req.last        = i_last_counter;
                expected_results.push_back(predict_filter_result(req));
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Present one request and hold it until the block takes it. Start stays
    // high on return so that back-to-back requests need no re-arm.
    task automatic send_request(input t_filter_request r);
        if (idle_enabled && $urandom_range(0, 5) == 0)
            idle_cycles($urandom_range(1, 16));
        i_op            <= r.op;
        i_counter_index <= r.counter;
        i_slot          <= r.slot;
        i_entry_kind    <= r.kind;
        i_entry_valid   <= r.entry_valid;
        i_bound_from    <= r.from_val;
        i_bound_to      <= r.to_val;
        i_stride        <= r.stride;
        i_counter_value <= r.value;
        i_last_counter  <= r.last;
        start           <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        requests_sent++;
    endtask

    // Drop start and hold until every outstanding result has arrived
    task automatic wait_until_idle(input int extra);
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_results.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_enable_mask(input logic [srpf_pkg::MASK_W-1:0] mask);
        i_cfg_data  <= mask;
        i_cfg_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        masks_applied++;
    endtask

    // Unused fields carry noise so that every input bit toggles
    function automatic t_filter_request make_write(
            input logic [srpf_pkg::CIDX_W-1:0]       ci,
            input logic [srpf_pkg::SLOT_W-1:0]       slot,
            input srpf_pkg::t_kind                   k,
            input logic                              vld,
            input logic signed [srpf_pkg::VAL_W-1:0] f,
            input logic signed [srpf_pkg::VAL_W-1:0] t,
            input logic signed [srpf_pkg::VAL_W-1:0] s);
        t_filter_request r;
        r.op          = srpf_pkg::OP_WRITE;
        r.counter     = ci;
        r.slot        = slot;
        r.kind        = k;
        r.entry_valid = vld;
        r.from_val    = f;
        r.to_val      = t;
        r.stride      = s;
        r.value       = $urandom();
        r.last        = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_filter_request make_query(
            input logic [srpf_pkg::CIDX_W-1:0]       ci,
            input logic signed [srpf_pkg::VAL_W-1:0] v,
            input logic                              last);
        t_filter_request r;
        r.op          = srpf_pkg::OP_QUERY;
        r.counter     = ci;
        r.slot        = 3'($urandom);
        r.kind        = srpf_pkg::t_kind'($urandom_range(0, 3));
        r.entry_valid = 1'($urandom_range(0, 1));
        r.from_val    = $urandom();
        r.to_val      = $urandom();
        r.stride      = $urandom();
        r.value       = v;
        r.last        = last;
        return r;
    endfunction

    function automatic logic signed [srpf_pkg::VAL_W-1:0] small_value(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic signed [srpf_pkg::VAL_W-1:0] wide_value();
        case ($urandom_range(0, 5))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return 0;
            3: return -1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly aim at a step point of a stored entry, so that the divisibility
    // path gets real hits rather than only misses
    function automatic logic signed [srpf_pkg::VAL_W-1:0] probe_value(
            input logic [srpf_pkg::CIDX_W-1:0] ci);
        int idx;
        int k;
        idx = int'(ci) * N_SLOTS + int'($urandom_range(0, N_SLOTS - 1));
        k   = int'($urandom_range(0, 8)) - 2;
        case ($urandom_range(0, 9))
            0, 1:    return wide_value();
            2, 3, 4: return small_value(128);
            default: begin
                if (ci >= N_COUNTERS || !entry_seen[idx])
                    return small_value(128);
                case (entry_kind_m[idx])
                    srpf_pkg::KIND_UPPER:
                        return entry_to_m[idx] + k * entry_stride_m[idx];
                    srpf_pkg::KIND_UNBOUNDED:
                        return k * entry_stride_m[idx];
                    default:
                        return entry_from_m[idx] + k * entry_stride_m[idx];
                endcase
            end
        endcase
    endfunction

    task automatic write_random_entry();
        logic [srpf_pkg::CIDX_W-1:0]       ci;
        logic signed [srpf_pkg::VAL_W-1:0] f;
        logic signed [srpf_pkg::VAL_W-1:0] t;
        logic signed [srpf_pkg::VAL_W-1:0] s;
        int                                span;
        ci = ($urandom_range(0, 9) == 0) ? srpf_pkg::CIDX_W'($urandom_range(11, 15))
                                          : srpf_pkg::CIDX_W'($urandom_range(0, 10));
        if ($urandom_range(0, 6) == 0) begin
            f = wide_value();
            t = wide_value();
            s = wide_value();
        end else begin
            // small, mostly consistent ranges: the end lies in the stride direction
            f    = small_value(64);
            s    = small_value(8);
            span = $urandom_range(0, 80);
            t    = (s < 0) ? f - span : f + span;
            if ($urandom_range(0, 7) == 0)
                t = small_value(64);
        end
        send_request(make_write(ci, 3'($urandom), srpf_pkg::t_kind'($urandom_range(0, 3)),
                                $urandom_range(0, 4) != 0, f, t, s));
    endtask

    // A page is one query per counter in order, last flag on the final one;
    // a tenth of the pages are broken sequences instead
    task automatic run_page();
        int                          n;
        logic [srpf_pkg::CIDX_W-1:0] ci;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 11);
            repeat (n) begin
                ci = srpf_pkg::CIDX_W'($urandom);
                send_request(make_query(ci, probe_value(ci), $urandom_range(0, 3) == 0));
            end
        end else begin
            for (int c = 0; c < N_COUNTERS; c++)
                send_request(make_query(srpf_pkg::CIDX_W'(c),
                                        probe_value(srpf_pkg::CIDX_W'(c)),
                                        c == N_COUNTERS - 1));
        end
    endtask

    task automatic run_traffic(input int until_count);
        while (requests_sent < until_count) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 6)) write_random_entry();
            else
                run_page();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // mask still at its reset value: every counter disabled, page selected
        send_request(make_query(4'd1, 5, 1'b1));
        wait_until_idle(4);
        set_enable_mask('1);

        // counter 1: one entry of each kind, the upper-only one with zero stride
        send_request(make_write(4'd1, 3'd0, srpf_pkg::KIND_BOUNDED, 1'b1, 10, 50, 5));
        send_request(make_write(4'd1, 3'd1, srpf_pkg::KIND_LOWER, 1'b1, -100, 0, -3));
        send_request(make_write(4'd1, 3'd2, srpf_pkg::KIND_UPPER, 1'b1, 0, 1000, 0));
        send_request(make_write(4'd1, 3'd3, srpf_pkg::KIND_UNBOUNDED, 1'b1, 0, 0, 7));
        // counter 2: extreme values, where the difference needs 33 bits
        send_request(make_write(4'd2, 3'd0, srpf_pkg::KIND_BOUNDED, 1'b1,
                                S32_MIN, S32_MAX, S32_MIN));
        send_request(make_write(4'd2, 3'd3, srpf_pkg::KIND_LOWER, 1'b1,
                                S32_MAX, 0, S32_MAX));
        send_request(make_write(4'd2, 3'd7, srpf_pkg::KIND_UNBOUNDED, 1'b1, 0, 0, 0));
        // counter 3: bounded range walked downwards
        send_request(make_write(4'd3, 3'd0, srpf_pkg::KIND_BOUNDED, 1'b1, 20, -20, -4));
        // counter index beyond the store: dropped
        send_request(make_write(4'd12, 3'd0, srpf_pkg::KIND_UNBOUNDED, 1'b1, 0, 0, 1));

        send_request(make_query(4'd1, 10, 1'b0));      // equality on the start value
        send_request(make_query(4'd1, 25, 1'b0));      // on a step inside the range
        send_request(make_query(4'd1, 27, 1'b0));      // miss everywhere
        send_request(make_query(4'd1, -106, 1'b0));    // lower-only, negative stride
        send_request(make_query(4'd1, 1000, 1'b0));    // zero stride, equality only
        send_request(make_query(4'd1, 49, 1'b0));      // unbounded multiple
        send_request(make_query(4'd2, 0, 1'b0));
        send_request(make_query(4'd2, S32_MAX, 1'b0));
        send_request(make_query(4'd2, S32_MIN, 1'b0));
        send_request(make_query(4'd3, -12, 1'b0));
        send_request(make_query(4'd15, 0, 1'b1));      // out-of-range counter closes page
        send_request(make_query(4'd0, 3, 1'b1));       // enabled counter, empty list

        // remove an entry, then close single-counter pages
        send_request(make_write(4'd1, 3'd0, srpf_pkg::KIND_BOUNDED, 1'b0, 10, 50, 5));
        send_request(make_query(4'd1, 10, 1'b1));
        send_request(make_query(4'd1, 49, 1'b1));
    endtask

    task automatic test_mask_extremes();
        logic [srpf_pkg::MASK_W-1:0] masks [4];
        masks = '{11'h000, 11'h7FF, 11'h001, 11'h400};
        foreach (masks[m]) begin
            wait_until_idle(4);
            set_enable_mask(masks[m]);
            repeat (3) write_random_entry();
            repeat (2) run_page();
        end
    endtask

    task automatic test_random_traffic();
        while (requests_sent < ITEMS_TARGET - STREAM_ITEMS) begin
            wait_until_idle(4);
            // favour dense masks so that most pages actually filter
            set_enable_mask(($urandom_range(0, 3) == 0) ? 11'h7FF
                            : srpf_pkg::MASK_W'($urandom | $urandom));
            run_traffic(requests_sent + 140);
        end
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        wait_until_idle(4);
        set_enable_mask(11'h7FF);
        run_traffic(ITEMS_TARGET);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (entry_live[i]) begin
            entry_live[i] = 1'b0;
            entry_seen[i] = 1'b0;
        end

        test_directed_cases();
        test_mask_extremes();
        test_random_traffic();
        test_back_to_back();

        wait_until_idle(SETTLE_CYCLES);
        $display("Covered %0d requests (%0d writes, %0d queries) under %0d enable masks.",
                 requests_sent, writes_seen, queries_seen, masks_applied);
        $display("Queries hit a slot %0d times; %0d pages closed, %0d selected; %0d mismatches.",
                 slot_hits, pages_closed, pages_selected, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/srpf_pkg.sv
design/strided_range_page_filter.sv
tb/tb_strided_range_page_filter.sv
